@@ rtl/wtwa_pkg.sv @@
// ----------------------------------------------------------------------------
// wtwa_pkg: shared types and constants
// Field widths, register indexes, mode and status codes, controller states
// and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package wtwa_pkg;

   localparam int TIME_W    = 32;
   localparam int VALUE_W   = 32;
   localparam int GAP_W     = 16;
   localparam int MODE_W    = 2;
   localparam int STATUS_W  = 2;
   localparam int RESULT_W  = 48;
   localparam int SUM_W     = 64;
   localparam int FRAC_W    = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam int COUNT_W   = 2;

   // dividend is |sum| shifted up by the fraction bits
   localparam int DIV_W     = SUM_W + FRAC_W;
   localparam int DIV_CNT_W = $clog2(DIV_W);

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_START   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_END     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_LIMIT      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_AGGREGATE_MODE = 2'd3;

   localparam logic [MODE_W-1:0] MODE_MIN  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MAX  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MEAN = 2'd2;

   localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY   = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_INVALID = 2'd2;

   localparam logic [TIME_W-1:0]  RST_WINDOW_START = 32'd0;
   localparam logic [TIME_W-1:0]  RST_WINDOW_END   = 32'd1;
   localparam logic [GAP_W-1:0]   RST_GAP_LIMIT    = 16'd300;
   localparam logic [MODE_W-1:0]  RST_MODE         = MODE_MEAN;

   localparam logic [RESULT_W-1:0] RESULT_POS_SAT = 48'h7FFF_FFFF_FFFF;
   localparam logic [RESULT_W-1:0] RESULT_NEG_SAT = 48'h8000_0000_0000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUTE,
      ST_WEIGH,
      ST_MULT,
      ST_ADD,
      ST_FINISH,
      ST_DIVIDE,
      ST_EMIT
   } fsm_state_type;

   typedef struct packed {
      logic accept;
      logic promote;
      logic weigh;
      logic sel_cur;
      logic mult;
      logic add;
      logic finish;
      logic div_step;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic held_valid;
      logic cur_last;
      logic need_div;
      logic div_last;
      logic out_free;
   } dp_status_type;

endpackage

@@ rtl/wtwa_controller.sv @@
// ----------------------------------------------------------------------------
// wtwa_controller: sequencing state machine
// Steps each sample through weigh, multiply and accumulate once its successor
// or the store's end is known, then runs finish, divide if needed, and emit.
// ----------------------------------------------------------------------------
module wtwa_controller
   import wtwa_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output dp_cmd_type    cmd,
   input  dp_status_type stat
);

   fsm_state_type state_ff, state_in;
   logic          phase_ff, phase_in;   // 0: held sample, 1: current sample

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               phase_in = 1'b0;
               state_in = stat.held_valid ? ST_WEIGH : ST_ROUTE;
            end
         end
         ST_ROUTE: begin
            if (stat.cur_last) begin
               phase_in = 1'b1;
               state_in = ST_WEIGH;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_WEIGH: state_in = ST_MULT;
         ST_MULT:  state_in = ST_ADD;
         ST_ADD: begin
            if (phase_ff) begin
               state_in = ST_FINISH;
            end else if (stat.cur_last) begin
               phase_in = 1'b1;
               state_in = ST_WEIGH;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FINISH: state_in = stat.need_div ? ST_DIVIDE : ST_EMIT;
         ST_DIVIDE: begin
            if (stat.div_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      cmd.sel_cur = phase_ff;
      unique case (state_ff)
         ST_IDLE:   cmd.accept   = req_valid;
         ST_ROUTE:  cmd.promote  = !stat.cur_last;
         ST_WEIGH:  cmd.weigh    = 1'b1;
         ST_MULT:   cmd.mult     = 1'b1;
         ST_ADD:    cmd.promote  = !phase_ff && !stat.cur_last;
         ST_FINISH: cmd.finish   = 1'b1;
         ST_DIVIDE: cmd.div_step = 1'b1;
         ST_EMIT:   cmd.emit     = stat.out_free;
         default:   cmd          = '0;
      endcase
      if (state_ff == ST_ADD) begin
         cmd.add = 1'b1;
      end
   end

endmodule

@@ rtl/wtwa_datapath.sv @@
// ----------------------------------------------------------------------------
// wtwa_datapath: sample store, weighting, accumulation and mean divider
// Holds configuration, the held and current samples, the accumulators, a
// bit-serial restoring divider and the result register.
// ----------------------------------------------------------------------------
module wtwa_datapath
   import wtwa_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata,
   input  logic [TIME_W-1:0]          req_sample_time,
   input  logic signed [VALUE_W-1:0]  req_sample_value,
   input  logic                       req_sample_last,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [RESULT_W-1:0] rsp_aggregate_value,
   output logic [STATUS_W-1:0]        rsp_aggregate_status,
   input  dp_cmd_type                 cmd,
   output dp_status_type              stat
);

   // configuration
   logic [TIME_W-1:0] win_start_ff, win_end_ff;
   logic [GAP_W-1:0]  gap_limit_ff;
   logic [MODE_W-1:0] mode_ff;

   // samples
   logic [TIME_W-1:0]         cur_time_ff, held_time_ff;
   logic signed [VALUE_W-1:0] cur_value_ff, held_value_ff;
   logic                      cur_last_ff, held_valid_ff;

   // accumulators
   logic [SUM_W-1:0]          wsum_ff;
   logic [TIME_W-1:0]         wtotal_ff;
   logic signed [VALUE_W-1:0] extreme_ff;
   logic                      seen_ff, order_err_ff;
   logic [COUNT_W-1:0]        count_ff;

   // multiply stage
   logic [TIME_W-1:0]         w_ff;
   logic signed [VALUE_W-1:0] v_ff;
   logic [SUM_W-1:0]          prod_ff;

   // finish and divider
   logic [STATUS_W-1:0] status_ff;
   logic [RESULT_W-1:0] value_ff;
   logic                neg_ff;
   logic [TIME_W-1:0]   rem_ff, rem_in;
   logic [DIV_W-1:0]    dq_ff, dq_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff;

   // result register
   logic                rsp_valid_ff;
   logic [RESULT_W-1:0] rsp_value_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   // ---------------- weighting ----------------
   logic [TIME_W-1:0]         s_time, gap, weight, w_sel;
   logic signed [VALUE_W-1:0] s_value, ext_new;
   logic                      has_next, in_win, after, gap_over;

   always_comb begin
      s_time   = cmd.sel_cur ? cur_time_ff  : held_time_ff;
      s_value  = cmd.sel_cur ? cur_value_ff : held_value_ff;
      has_next = !cmd.sel_cur;
      in_win   = (s_time >= win_start_ff) && (s_time < win_end_ff);
      gap      = cur_time_ff - s_time;
      after    = cur_time_ff > s_time;
      gap_over = gap > {{(TIME_W-GAP_W){1'b0}}, gap_limit_ff};
      weight   = TIME_W'(1);
      if (has_next && after) begin
         if (cur_time_ff < win_end_ff) begin
            weight = gap_over ? TIME_W'(1) : gap;
         end else if ((cur_time_ff != win_end_ff) && !gap_over) begin
            // cut at the window end
            weight = win_end_ff - s_time;
         end
      end
      w_sel = in_win ? weight : '0;

      ext_new = extreme_ff;
      if (!seen_ff) begin
         ext_new = s_value;
      end else if ((mode_ff == MODE_MIN) && (s_value < extreme_ff)) begin
         ext_new = s_value;
      end else if ((mode_ff == MODE_MAX) && (s_value > extreme_ff)) begin
         ext_new = s_value;
      end
   end

   // signed value times unsigned weight, low 64 bits kept
   logic signed [VALUE_W:0]     mul_a, mul_b;
   logic signed [2*VALUE_W+1:0] prod_full;

   assign mul_a     = {v_ff[VALUE_W-1], v_ff};
   assign mul_b     = {1'b0, w_ff};
   assign prod_full = mul_a * mul_b;

   // ---------------- finish ----------------
   logic                invalid, mean_path;
   logic [STATUS_W-1:0] fin_status;
   logic [RESULT_W-1:0] fin_value;
   logic [SUM_W-1:0]    mag;

   always_comb begin
      invalid = (win_start_ff >= win_end_ff) || order_err_ff || (mode_ff > MODE_MEAN);
      priority if (invalid) begin
         fin_status = STAT_INVALID;
      end else if (!seen_ff) begin
         fin_status = STAT_EMPTY;
      end else begin
         fin_status = STAT_OK;
      end
      mean_path = (mode_ff == MODE_MEAN) && (count_ff != COUNT_W'(1));
      if ((fin_status == STAT_OK) && !mean_path) begin
         fin_value = {extreme_ff, {FRAC_W{1'b0}}};
      end else begin
         // a mean over a wrapped-to-zero weight total is zero
         fin_value = '0;
      end
      mag = wsum_ff[SUM_W-1] ? (~wsum_ff + SUM_W'(1)) : wsum_ff;
   end

   // ---------------- divider step ----------------
   logic [TIME_W:0]     rem_sh;
   logic                ge;
   logic                sat;
   logic [RESULT_W-1:0] q_mag, mean_val;

   always_comb begin
      rem_sh = {rem_ff, dq_ff[DIV_W-1]};
      ge     = rem_sh >= {1'b0, wtotal_ff};
      rem_in = ge ? TIME_W'(rem_sh - {1'b0, wtotal_ff}) : rem_sh[TIME_W-1:0];
      dq_in  = {dq_ff[DIV_W-2:0], ge};
      sat    = |dq_in[DIV_W-1:RESULT_W-1];
      if (sat) begin
         q_mag = neg_ff ? RESULT_NEG_SAT : RESULT_POS_SAT;
      end else begin
         q_mag = dq_in[RESULT_W-1:0];
      end
      mean_val = neg_ff ? (~q_mag + RESULT_W'(1)) : q_mag;
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         win_start_ff <= RST_WINDOW_START;
         win_end_ff   <= RST_WINDOW_END;
         gap_limit_ff <= RST_GAP_LIMIT;
         mode_ff      <= RST_MODE;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_WINDOW_START:   win_start_ff <= csr_wdata[TIME_W-1:0];
            CSR_WINDOW_END:     win_end_ff   <= csr_wdata[TIME_W-1:0];
            CSR_GAP_LIMIT:      gap_limit_ff <= csr_wdata[GAP_W-1:0];
            CSR_AGGREGATE_MODE: mode_ff      <= csr_wdata[MODE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.emit) begin
         held_time_ff  <= '0;
         held_value_ff <= '0;
         held_valid_ff <= 1'b0;
         wsum_ff       <= '0;
         wtotal_ff     <= '0;
         extreme_ff    <= '0;
         seen_ff       <= 1'b0;
         count_ff      <= '0;
         order_err_ff  <= 1'b0;
         cur_last_ff   <= 1'b0;
      end else begin
         if (cmd.accept) begin
            cur_time_ff  <= req_sample_time;
            cur_value_ff <= req_sample_value;
            cur_last_ff  <= req_sample_last;
            if (count_ff != COUNT_W'(2)) begin
               count_ff <= count_ff + COUNT_W'(1);
            end
            if (held_valid_ff && (req_sample_time <= held_time_ff)) begin
               order_err_ff <= 1'b1;
            end
         end
         if (cmd.promote) begin
            held_time_ff  <= cur_time_ff;
            held_value_ff <= cur_value_ff;
            held_valid_ff <= 1'b1;
         end
         if (cmd.weigh && in_win) begin
            extreme_ff <= ext_new;
            seen_ff    <= 1'b1;
            wtotal_ff  <= wtotal_ff + w_sel;
         end
         if (cmd.add) begin
            wsum_ff <= wsum_ff + prod_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.weigh) begin
         w_ff <= w_sel;
         v_ff <= s_value;
      end
      if (cmd.mult) begin
         prod_ff <= prod_full[SUM_W-1:0];
      end
      if (cmd.finish) begin
         status_ff <= fin_status;
         value_ff  <= fin_value;
         neg_ff    <= wsum_ff[SUM_W-1];
         rem_ff    <= '0;
         dq_ff     <= {mag, {FRAC_W{1'b0}}};
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         dq_ff  <= dq_in;
         if (stat.div_last) begin
            value_ff <= mean_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.finish) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_value_ff  <= value_ff;
         rsp_status_ff <= status_ff;
      end
   end

   always_comb begin
      stat.held_valid = held_valid_ff;
      stat.cur_last   = cur_last_ff;
      stat.need_div   = (fin_status == STAT_OK) && mean_path && (wtotal_ff != '0);
      stat.div_last   = (div_cnt_ff == DIV_CNT_W'(DIV_W-1));
      stat.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_aggregate_value  = rsp_value_ff;
   assign rsp_aggregate_status = rsp_status_ff;

endmodule

@@ rtl/windowed_time_weighted_aggregate.sv @@
// A sample that is not last is accepted, weighed, multiplied and accumulated; the
// first of a store is accepted and routed only. A last sample is weighed, multiplied
// and accumulated after any held one, then finished and emitted; a mean over two or
// more samples with a nonzero weight total also runs the 80-step divider. A new
// sample waits until the block is idle; one result per store; a stalled one holds.
// Reset: synchronous, active high; registers return to their defaults.
// ----------------------------------------------------------------------------
// windowed_time_weighted_aggregate: min, max or time-weighted mean
// Accumulates a store of timestamped samples over a window and reports one
// aggregate with status on the final sample.
// ----------------------------------------------------------------------------
module windowed_time_weighted_aggregate
   import wtwa_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [TIME_W-1:0]          req_sample_time,
   input  logic signed [VALUE_W-1:0]  req_sample_value,
   input  logic                       req_sample_last,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [RESULT_W-1:0] rsp_aggregate_value,
   output logic [STATUS_W-1:0]        rsp_aggregate_status
);

   dp_cmd_type    cmd;
   dp_status_type stat;

   wtwa_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   wtwa_datapath u_dp (
      .clock                (clock),
      .reset                (reset),
      .csr_write            (csr_write),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_sample_time      (req_sample_time),
      .req_sample_value     (req_sample_value),
      .req_sample_last      (req_sample_last),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_aggregate_value  (rsp_aggregate_value),
      .rsp_aggregate_status (rsp_aggregate_status),
      .cmd                  (cmd),
      .stat                 (stat)
   );

endmodule

@@ rtl/wtwa_checker.sv @@
// ----------------------------------------------------------------------------
// wtwa_checker: port-level checks
// Watches the top-level ports for result and sequencing rules.
// ----------------------------------------------------------------------------
module wtwa_checker
   import wtwa_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       csr_write,
   input logic [CSR_IDX_W-1:0]       csr_index,
   input logic [CSR_DATA_W-1:0]      csr_wdata,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic [TIME_W-1:0]          req_sample_time,
   input logic signed [VALUE_W-1:0]  req_sample_value,
   input logic                       req_sample_last,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic signed [RESULT_W-1:0] rsp_aggregate_value,
   input logic [STATUS_W-1:0]        rsp_aggregate_status
);

   // a failed or empty window carries a zero value
   a_nonok_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_aggregate_status != STAT_OK) |-> rsp_aggregate_value == '0)
      else $error("non-ok result with nonzero value");

   // the final sample of a store always occupies the block for work
   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_sample_last |=> req_stall)
      else $error("block free right after final sample");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_aggregate_value)
                                 && $stable(rsp_aggregate_status))
      else $error("stalled result dropped or changed");

endmodule

bind windowed_time_weighted_aggregate wtwa_checker u_wtwa_checker (.*);

@@ tb/tb_windowed_time_weighted_aggregate.sv @@
// ----------------------------------------------------------------------------
// tb_windowed_time_weighted_aggregate: self-checking bench for the aggregate
// Streams stores of timestamped samples through the block under a range of
// window, gap-limit and mode settings, predicts each store's min, max or
// time-weighted mean with status, and checks every result in order. The
// request channel idles and the result channel stalls at random.
// ----------------------------------------------------------------------------
module tb_windowed_time_weighted_aggregate;
   import wtwa_pkg::*;

   localparam logic [MODE_W-1:0] MODE_UNDEFINED = 2'd3;
   localparam int DRAIN_CYCLES = 100;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int RANDOM_SAMPLES = 2000;

   typedef struct packed {
      logic signed [RESULT_W-1:0] value;
      logic [STATUS_W-1:0]        status;
   } aggregate_result_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_wdata = '0;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [TIME_W-1:0]          req_sample_time = '0;
   logic signed [VALUE_W-1:0]  req_sample_value = '0;
   logic                       req_sample_last = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [RESULT_W-1:0] rsp_aggregate_value;
   logic [STATUS_W-1:0]        rsp_aggregate_status;

   windowed_time_weighted_aggregate uut (
      .clock                (clock),
      .reset                (reset),
      .csr_write            (csr_write),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_sample_time      (req_sample_time),
      .req_sample_value     (req_sample_value),
      .req_sample_last      (req_sample_last),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_aggregate_value  (rsp_aggregate_value),
      .rsp_aggregate_status (rsp_aggregate_status)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predicted register settings
   logic [TIME_W-1:0] cfg_start = RST_WINDOW_START;
   logic [TIME_W-1:0] cfg_stop = RST_WINDOW_END;
   logic [GAP_W-1:0]  cfg_gap_limit = RST_GAP_LIMIT;
   logic [MODE_W-1:0] cfg_mode = RST_MODE;

   // predicted store accumulation
   logic [TIME_W-1:0]         prev_time = '0;
   logic signed [VALUE_W-1:0] prev_value = '0;
   logic                      prev_present = 1'b0;
   logic [SUM_W-1:0]          sum_acc = '0;
   logic [31:0]               weight_acc = '0;
   logic signed [VALUE_W-1:0] extreme_acc = '0;
   logic                      window_hit = 1'b0;
   logic [COUNT_W-1:0]        samples_seen = '0;
   logic                      order_bad = 1'b0;

   aggregate_result_type expected_aggregates[$];
   int mismatch_count = 0;
   int samples_sent = 0;
   int cycle_count = 0;
   logic idling_on = 1'b1;
   int rsp_burst_left = 0;

   function automatic void clear_store();
      prev_time = '0;
      prev_value = '0;
      prev_present = 1'b0;
      sum_acc = '0;
      weight_acc = '0;
      extreme_acc = '0;
      window_hit = 1'b0;
      samples_seen = '0;
      order_bad = 1'b0;
   endfunction

   function automatic void weigh_sample(input logic [TIME_W-1:0] t,
                                        input logic signed [VALUE_W-1:0] v,
                                        input logic has_next,
                                        input logic [TIME_W-1:0] t_next);
      logic [31:0] w;
      logic [31:0] gap;
      if (t < cfg_start || t >= cfg_stop) return;
      if (!window_hit) begin
         extreme_acc = v;
      end else if (cfg_mode == MODE_MIN) begin
         if (v < extreme_acc) extreme_acc = v;
      end else if (cfg_mode == MODE_MAX) begin
         if (v > extreme_acc) extreme_acc = v;
      end
      window_hit = 1'b1;
      w = 32'd1;
      if (has_next && t_next > t) begin
         gap = t_next - t;
         if (t_next < cfg_stop) begin
            w = (gap > cfg_gap_limit) ? 32'd1 : gap;
         end else if (t_next != cfg_stop && gap <= cfg_gap_limit) begin
            // cut the weight at the window end
            w = cfg_stop - t;
         end
      end
      weight_acc = weight_acc + w;
      sum_acc = sum_acc + {{32{v[VALUE_W-1]}}, v} * {32'd0, w};
   endfunction

   function automatic logic [RESULT_W-1:0] mean_of_store();
      logic             neg;
      logic [SUM_W-1:0] mag;
      logic [SUM_W-1:0] quot;
      logic [SUM_W-1:0] rem;
      logic [SUM_W-1:0] res;
      if (weight_acc == 0) return '0;
      neg = sum_acc[SUM_W-1];
      mag = neg ? (64'd0 - sum_acc) : sum_acc;
      quot = mag / {32'd0, weight_acc};
      rem = mag % {32'd0, weight_acc};
      if (quot > 64'h7FFF_FFFF) begin
         res = neg ? {16'd0, RESULT_NEG_SAT} : {16'd0, RESULT_POS_SAT};
      end else begin
         res = (quot << FRAC_W) | ((rem << FRAC_W) / {32'd0, weight_acc});
      end
      if (neg) res = 64'd0 - res;
      return res[RESULT_W-1:0];
   endfunction

   function automatic void predict_sample(input logic [TIME_W-1:0] t,
                                          input logic signed [VALUE_W-1:0] v,
                                          input logic last);
      aggregate_result_type want;
      if (prev_present) begin
         if (t <= prev_time) order_bad = 1'b1;
         weigh_sample(prev_time, prev_value, 1'b1, t);
      end
      if (samples_seen < 2) samples_seen = samples_seen + 1'b1;
      if (!last) begin
         // hold this sample until the gap to the next one is known
         prev_time = t;
         prev_value = v;
         prev_present = 1'b1;
         return;
      end
      weigh_sample(t, v, 1'b0, '0);
      want.value = '0;
      if (cfg_start >= cfg_stop || order_bad || cfg_mode > MODE_MEAN) begin
         want.status = STAT_INVALID;
      end else if (!window_hit) begin
         want.status = STAT_EMPTY;
      end else begin
         want.status = STAT_OK;
         if (cfg_mode == MODE_MEAN && samples_seen != 1) want.value = mean_of_store();
         else want.value = {extreme_acc, 16'h0000};
      end
      expected_aggregates.push_back(want);
      clear_store();
   endfunction

   function automatic int pick_idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(11, 40);
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return 32'sh8000_0000;
      if (r < 16) return 32'sh7FFF_FFFF;
      if (r < 40) return $signed($urandom_range(0, 200)) - 32'sd100;
      return $urandom;
   endfunction

   task automatic note_mismatch(input string what, input logic [RESULT_W-1:0] want,
                                input logic [RESULT_W-1:0] got);
      if (mismatch_count < 10)
         $display("mismatch at cycle %0d: %s expected %h got %h", cycle_count, what, want, got);
      mismatch_count++;
   endtask

   // check each result transfer against the oldest prediction
   always @(posedge clock) begin
      aggregate_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_aggregates.size() == 0) begin
            note_mismatch("unexpected result, status", '0,
                          RESULT_W'(rsp_aggregate_status));
         end else begin
            want = expected_aggregates.pop_front();
            if (rsp_aggregate_value !== want.value)
               note_mismatch("aggregate_value", want.value, rsp_aggregate_value);
            if (rsp_aggregate_status !== want.status)
               note_mismatch("aggregate_status", RESULT_W'(want.status),
                             RESULT_W'(rsp_aggregate_status));
         end
      end
   end

   // receiver back-pressure in bursts
   always @(posedge clock) begin
      if (rsp_burst_left > 0) begin
         rsp_burst_left--;
      end else if (!idling_on || $urandom_range(0, 1) == 0) begin
         rsp_stall <= 1'b0;
         rsp_burst_left = $urandom_range(0, 12);
      end else begin
         rsp_stall <= 1'b1;
         rsp_burst_left = pick_idle_length() - 1;
      end
   end

   task automatic send_sample(input logic [TIME_W-1:0] t, input logic signed [VALUE_W-1:0] v,
                              input logic last);
      int gap;
      gap = (!idling_on || $urandom_range(0, 1) == 0) ? 0 : pick_idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_time <= t;
      req_sample_value <= v;
      req_sample_last <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_sample(t, v, last);
      samples_sent++;
   endtask

   // wait out all pending results, then the block's own latency
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_aggregates.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      case (index)
         CSR_WINDOW_START:   cfg_start = data;
         CSR_WINDOW_END:     cfg_stop = data;
         CSR_GAP_LIMIT:      cfg_gap_limit = data[GAP_W-1:0];
         CSR_AGGREGATE_MODE: cfg_mode = data[MODE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic write_config(input logic [TIME_W-1:0] start_time,
                               input logic [TIME_W-1:0] stop_time,
                               input logic [GAP_W-1:0] limit,
                               input logic [MODE_W-1:0] mode);
      logic [31:0] noise;
      noise = $urandom;
      write_register(CSR_WINDOW_START, start_time);
      write_register(CSR_WINDOW_END, stop_time);
      // unused upper bits carry noise
      write_register(CSR_GAP_LIMIT, {noise[31:16], limit});
      write_register(CSR_AGGREGATE_MODE, {noise[29:0], mode});
      csr_write <= 1'b0;
   endtask

   task automatic test_reset_defaults();
      send_sample(32'd0, pick_value(), 1'b1);
      send_sample(32'd0, pick_value(), 1'b0);
      send_sample(32'd5, pick_value(), 1'b1);
   endtask

   task automatic test_window_edges();
      settle();
      write_config(32'd100, 32'd200, 16'd10, MODE_MEAN);
      // inside gap, over-limit gaps, and a cut at the window end
      send_sample(32'd90, pick_value(), 1'b0);
      send_sample(32'd150, pick_value(), 1'b0);
      send_sample(32'd155, pick_value(), 1'b0);
      send_sample(32'd170, pick_value(), 1'b0);
      send_sample(32'd195, pick_value(), 1'b0);
      send_sample(32'd205, pick_value(), 1'b1);
      // next sample exactly at the window end
      send_sample(32'd195, pick_value(), 1'b0);
      send_sample(32'd200, pick_value(), 1'b1);
      // past the end beyond the limit
      send_sample(32'd199, pick_value(), 1'b0);
      send_sample(32'd230, pick_value(), 1'b1);
      send_sample(32'd100, pick_value(), 1'b1);
   endtask

   task automatic test_status_codes();
      send_sample(32'd10, pick_value(), 1'b0);
      send_sample(32'd250, pick_value(), 1'b1);
      send_sample(32'd120, pick_value(), 1'b0);
      send_sample(32'd120, pick_value(), 1'b1);
      send_sample(32'd130, pick_value(), 1'b0);
      send_sample(32'd125, pick_value(), 1'b1);
      settle();
      write_config(32'd500, 32'd500, 16'd10, MODE_MEAN);
      send_sample(32'd500, pick_value(), 1'b1);
      settle();
      write_config(32'd100, 32'd200, 16'd10, MODE_UNDEFINED);
      send_sample(32'd150, pick_value(), 1'b1);
   endtask

   task automatic test_aggregate_modes();
      settle();
      write_config(32'd0, 32'hFFFF_FFFF, 16'hFFFF, MODE_MEAN);
      // most negative mean saturates
      send_sample(32'd0, 32'sh8000_0000, 1'b0);
      send_sample(32'h0001_0000, 32'sh8000_0000, 1'b0);
      send_sample(32'hFFFF_FFFF, 32'sh8000_0000, 1'b1);
      settle();
      write_config(32'd0, 32'hFFFF_FFFF, 16'd1, MODE_MIN);
      send_sample(32'd1, 32'sh7FFF_FFFF, 1'b0);
      send_sample(32'd2, 32'sh8000_0000, 1'b0);
      send_sample(32'd3, 32'sd5, 1'b1);
      settle();
      write_config(32'd0, 32'hFFFF_FFFF, 16'd1, MODE_MAX);
      send_sample(32'd1, 32'sh8000_0000, 1'b0);
      send_sample(32'd2, 32'sh7FFF_FFFF, 1'b0);
      send_sample(32'd3, -32'sd5, 1'b1);
   endtask

   task automatic randomize_config();
      logic [TIME_W-1:0] start_time;
      logic [TIME_W-1:0] stop_time;
      logic [63:0]       span_end;
      logic [GAP_W-1:0]  limit;
      logic [MODE_W-1:0] mode;
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) start_time = '0;
      else if (r < 25) start_time = 32'hFFFF_FFFF - $urandom_range(0, 5000);
      else start_time = $urandom;
      r = $urandom_range(0, 99);
      if (r < 6) begin
         stop_time = start_time;
      end else if (r < 12) begin
         stop_time = (start_time > 0) ? start_time - $urandom_range(1, start_time) : '0;
      end else if (r < 22) begin
         stop_time = 32'hFFFF_FFFF;
      end else begin
         span_end = {32'd0, start_time} + $urandom_range(1, 4000);
         stop_time = (span_end > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : span_end[31:0];
      end
      r = $urandom_range(0, 99);
      if (r < 15) limit = 16'd1;
      else if (r < 30) limit = 16'hFFFF;
      else limit = GAP_W'($urandom_range(1, 600));
      if ($urandom_range(0, 99) < 8) mode = MODE_UNDEFINED;
      else mode = MODE_W'($urandom_range(MODE_MIN, MODE_MEAN));
      write_config(start_time, stop_time, limit, mode);
   endtask

   task automatic random_store();
      logic [63:0] t;
      logic [63:0] span;
      logic [63:0] step_max;
      int count;
      int r;
      int back;
      r = $urandom_range(0, 99);
      if (r < 10) count = 1;
      else if (r < 90) count = $urandom_range(2, 10);
      else count = $urandom_range(11, 40);
      span = (cfg_stop > cfg_start) ? {32'd0, cfg_stop - cfg_start} : 64'd64;
      step_max = span / count + 1;
      if (step_max > cfg_gap_limit + cfg_gap_limit / 4 + 1)
         step_max = cfg_gap_limit + cfg_gap_limit / 4 + 1;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         t = {32'd0, $urandom};
      end else if (r < 20) begin
         // straddle the window end
         back = $urandom_range(0, 32'(3 * step_max));
         t = (cfg_stop >= back) ? cfg_stop - back : 64'd0;
      end else begin
         back = $urandom_range(0, 32'(2 * step_max));
         t = (cfg_start >= back) ? cfg_start - back : 64'd0;
      end
      for (int i = 0; i < count; i++) begin
         send_sample(t[TIME_W-1:0], pick_value(), i == count - 1);
         r = $urandom_range(0, 99);
         if (r < 3) begin
            back = $urandom_range(0, 3);
            if (t >= back) t = t - back;
         end else if (r < 13) begin
            t = t + cfg_gap_limit + $urandom_range(1, 1000);
         end else begin
            t = t + $urandom_range(1, 32'(step_max));
         end
      end
   endtask

   task automatic test_random_stores();
      int target;
      target = samples_sent + RANDOM_SAMPLES;
      while (samples_sent < target) begin
         settle();
         randomize_config();
         idling_on = ($urandom_range(0, 5) != 0);
         repeat ($urandom_range(5, 20)) random_store();
      end
      idling_on = 1'b1;
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_windowed_time_weighted_aggregate failed");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_window_edges();
      test_status_codes();
      test_aggregate_modes();
      test_random_stores();
      settle();
      if (mismatch_count == 0) begin
         $display("tb_windowed_time_weighted_aggregate passed");
      end else begin
         $display("tb_windowed_time_weighted_aggregate failed");
      end
      $finish;
   end

endmodule
